// ----- hdl/repeated_kmer_detector_unit_assert.svh -----
// Assertion macros for the repeated k-mer detector.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef REPEATED_KMER_DETECTOR_UNIT_ASSERT_SVH
`define REPEATED_KMER_DETECTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define RKD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("rkd assertion failed");
// Check that a condition is followed by an outcome in the next cycle
`define RKD_ASSERT_NEXT(label, cond, outcome) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (outcome)) else $error("rkd assertion failed");
`else
`define RKD_ASSERT(label, prop)
`define RKD_ASSERT_NEXT(label, cond, outcome)
`endif

`endif

// ----- hdl/rkd_pkg.sv -----
// Shared types and constants of the repeated k-mer detector.
// No dependencies; used by rkd_counter and the top level.
package rkd_pkg;

    // widest code and table index
    localparam int TABLE_BITS = 20;

    // sequence tag kept with each counter entry
    localparam int EPOCH_W = 6;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    // saturating counter values
    localparam logic [1:0] CNT_ONE = 2'd1;
    localparam logic [1:0] CNT_MAX = 2'd3;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [1:0]         cnt;
    } t_entry;

    // control from the top level to the counter table
    typedef struct packed {
        logic lookup;   // look up the presented window code
        logic start;    // new sequence begins
        logic adv;      // the pending update may complete
    } t_tbl_req;

    // status from the counter table
    typedef struct packed {
        logic busy;     // clearing sweep in progress
        logic s1_vld;   // an update is pending
        logic hit;      // the pending update reaches two this cycle
    } t_tbl_rsp;

endpackage

// ----- hdl/rkd_counter.sv -----
// Occurrence counter table: memory, read-modify-write stage with forwarding,
// sequence tags and the clearing sweep. Depends on rkd_pkg and the assert header.
`include "repeated_kmer_detector_unit_assert.svh"

module rkd_counter import rkd_pkg::*; #(
    parameter int CODE_W = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_req          i_req,
    input  logic [CODE_W-1:0] i_addr,
    output t_tbl_rsp          o_rsp,
    output logic [CODE_W-1:0] o_code
);

    localparam int DEPTH = 1 << CODE_W;

    t_entry             r_mem [DEPTH];
    t_entry             r_rd;
    t_state             r_state;
    t_state             n_state;
    logic [EPOCH_W-1:0] r_epoch;
    logic [CODE_W-1:0]  r_clr_addr;
    logic               r_s1_vld;
    logic [CODE_W-1:0]  r_s1_addr;
    logic               r_fw_vld;
    logic [CODE_W-1:0]  r_fw_addr;
    t_entry             r_fw_data;

    logic               clearing;
    logic               clr_last;
    logic               s1_go;
    logic               fw_hit;
    t_entry             cur_word;
    logic [1:0]         cur_cnt;
    logic [1:0]         new_cnt;
    t_entry             wr_word;

    // pick the freshest copy of the entry and bump its counter
    always_comb begin
        clr_last = &r_clr_addr;
        s1_go    = r_s1_vld && i_req.adv;
        fw_hit   = r_fw_vld && (r_fw_addr == r_s1_addr);
        cur_word = fw_hit ? r_fw_data : r_rd;
        cur_cnt  = (cur_word.tag == r_epoch) ? cur_word.cnt : 2'd0;
        new_cnt  = (cur_cnt == CNT_MAX) ? CNT_MAX : cur_cnt + 2'd1;
        wr_word  = '{tag: r_epoch, cnt: new_cnt};
    end

    // next state of the sweep control
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_req.start && (r_epoch == EPOCH_LAST)) begin
                    n_state = ST_CLEAR;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // outputs of the sweep control
    always_comb begin
        case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    // memory: sweep or update write, registered read on lookup
    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (s1_go) begin
            r_mem[r_s1_addr] <= wr_word;
        end
        if (i_req.lookup) begin
            r_rd <= r_mem[i_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_epoch    <= '0;
            r_clr_addr <= '0;
            r_s1_vld   <= 1'b0;
            r_fw_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            // advance the sweep; it wraps to zero for the next pass
            if (clearing) begin
                r_clr_addr <= r_clr_addr + CODE_W'(1);
            end
            if (i_req.start) begin
                r_epoch <= r_epoch + EPOCH_W'(1);
            end
            // load or drain the update stage
            if (i_req.lookup) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            // hold the last write for the lookup that raced it
            if (clearing) begin
                r_fw_vld <= 1'b0;
            end else if (s1_go) begin
                r_fw_vld <= 1'b1;
            end
        end
    end

    // payload of the update stage and forwarding register
    always_ff @(posedge i_clk) begin
        if (i_req.lookup) begin
            r_s1_addr <= i_addr;
        end
        if (s1_go) begin
            r_fw_addr <= r_s1_addr;
            r_fw_data <= wr_word;
        end
    end

    assign o_rsp.busy   = clearing;
    assign o_rsp.s1_vld = r_s1_vld;
    assign o_rsp.hit    = s1_go && (cur_cnt == CNT_ONE);
    assign o_code       = r_s1_addr;

    `RKD_ASSERT(a_no_lookup_in_sweep, !(i_req.lookup && clearing))
    `RKD_ASSERT(a_no_start_in_sweep, !(i_req.start && clearing))
    `RKD_ASSERT_NEXT(a_wrap_sweeps, i_req.start && (r_epoch == EPOCH_LAST), clearing)
    `RKD_ASSERT_NEXT(a_held_update, r_s1_vld && !i_req.adv, r_s1_vld && $stable(r_s1_addr))

endmodule

// ----- hdl/repeated_kmer_detector_unit.sv -----
// Repeated k-mer detector, top level: input handshake, rolling window and
// fill count, output register. Depends on rkd_pkg and rkd_counter.
//
// Accepts one word per cycle unless o_stall is high: a base or a start marker.
// Each base is shifted into a window of the last min(WINDOW_LEN,10) 2-bit codes;
// once the window is full its counter is read from a table memory through a
// registered read and written back from the update stage, with forwarding so
// that a base can follow in every cycle while the output is free. A k-mer code
// is issued through an output register for the base that makes its counter
// reach two; the input stalls while it waits and an update is pending. A start
// marker retires the table by advancing a 6-bit sequence tag; on every 64th
// start, and after reset, a clearing sweep writes one entry per cycle to all
// 2^min(2*WINDOW_LEN,20) entries (1,048,576 at the default) with input stalled.
module repeated_kmer_detector_unit import rkd_pkg::*; #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_kind,
    input  logic [7:0]            i_nucleotide,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [TABLE_BITS-1:0] o_kmer_code
);

    localparam int CODE_W = (2 * WINDOW_LEN >= TABLE_BITS) ? TABLE_BITS : 2 * WINDOW_LEN;
    localparam int FILL_W = $clog2(WINDOW_LEN);

    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    // map a character to its base code; anything else counts as A
    function automatic logic [1:0] base_code(input logic [7:0] ch);
        case (ch)
            CHAR_C:  base_code = 2'd1;
            CHAR_G:  base_code = 2'd2;
            CHAR_T:  base_code = 2'd3;
            default: base_code = 2'd0;
        endcase
    endfunction

    logic [CODE_W-1:0] r_window;
    logic [CODE_W-1:0] n_window;
    logic [FILL_W-1:0] r_fill;
    logic              r_out_vld;
    logic [CODE_W-1:0] r_out_code;

    logic              accept;
    logic              full;
    logic              out_free;
    t_tbl_req          tbl_req;
    t_tbl_rsp          tbl_rsp;
    logic [CODE_W-1:0] tbl_code;

    // handshake and table control
    always_comb begin
        out_free       = !r_out_vld || !i_stall;
        o_stall        = tbl_rsp.busy || (tbl_rsp.s1_vld && !out_free);
        accept         = i_valid && !o_stall;
        full           = (r_fill == FILL_W'(WINDOW_LEN - 1));
        n_window       = {r_window[CODE_W-3:0], base_code(i_nucleotide)};
        tbl_req.lookup = accept && !i_kind && full;
        tbl_req.start  = accept && i_kind;
        tbl_req.adv    = out_free;
    end

    // advance the window and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
        end else if (accept) begin
            if (i_kind) begin
                r_window <= '0;
                r_fill   <= '0;
            end else begin
                r_window <= n_window;
                if (!full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
        end
    end

    // hold the result word until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (tbl_rsp.hit) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_rsp.hit) begin
            r_out_code <= tbl_code;
        end
    end

    rkd_counter #(
        .CODE_W (CODE_W)
    ) u_counter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .i_addr  (n_window),
        .o_rsp   (tbl_rsp),
        .o_code  (tbl_code)
    );

    assign o_valid     = r_out_vld;
    assign o_kmer_code = TABLE_BITS'(r_out_code);

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for repeated_kmer_detector_unit: directed and random
// base streams, k-mer prediction with a sparse occurrence table, random stalls.
// Depends on rkd_pkg and the repeated_kmer_detector_unit RTL.
module tb_top import rkd_pkg::*;;

    localparam int WINDOW_LEN   = 10;
    localparam int CODE_W       = (2 * WINDOW_LEN >= TABLE_BITS) ? TABLE_BITS : 2 * WINDOW_LEN;
    localparam logic [TABLE_BITS-1:0] CODE_MASK = TABLE_BITS'((64'd1 << CODE_W) - 64'd1);
    localparam int RANDOM_WORDS = 400;
    localparam int TAIL_WORDS   = 60;
    localparam int MAX_STARTS   = 50;    // stay clear of the tag-wrap sweep
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_LIMIT   = 1 << 22;

    localparam logic KIND_BASE  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_T = 8'h54;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;
    localparam logic [1:0] CNT_SAT = 2'd3;
    localparam logic [1:0] CNT_REPEAT = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] nuc;
    } t_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  i_kind = 1'b0;
    logic [7:0]            i_nucleotide = 8'h00;
    logic                  i_stall = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [TABLE_BITS-1:0] o_kmer_code;

    // stimulus and predictor state
    t_word                 pending_words[$];
    logic [TABLE_BITS-1:0] expected_kmers[$];
    logic [1:0]            kmer_count[int unsigned];
    logic [TABLE_BITS-1:0] win_code = '0;
    int unsigned           bases_seen = 0;

    int total_words = 0;
    int n_accepted = 0;
    int n_starts = 0;
    int n_results = 0;
    int n_errors = 0;
    int send_gap = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    bit hold_done = 1'b0;
    t_word next_word;
    logic [TABLE_BITS-1:0] want_code;

    repeated_kmer_detector_unit #(
        .WINDOW_LEN(WINDOW_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_nucleotide(i_nucleotide),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kmer_code (o_kmer_code)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // map a character byte to its 2-bit base code
    function automatic logic [1:0] base_of(input logic [7:0] ch);
        case (ch)
            CH_C:    return CODE_C;
            CH_G:    return CODE_G;
            CH_T:    return CODE_T;
            default: return CODE_A;
        endcase
    endfunction

    // advance the window on one accepted word and queue the k-mer it repeats
    task automatic predict_kmer(input logic kind, input logic [7:0] ch);
        logic [1:0] cnt;
        if (kind == KIND_START) begin
            win_code   = '0;
            bases_seen = 0;
            kmer_count.delete();
            return;
        end
        win_code = ((win_code << 2) | TABLE_BITS'(base_of(ch))) & CODE_MASK;
        if (bases_seen < WINDOW_LEN - 1) begin
            bases_seen++;
            return;
        end
        cnt = kmer_count.exists(win_code) ? kmer_count[win_code] : 2'd0;
        if (cnt != CNT_SAT) begin
            cnt++;
            kmer_count[win_code] = cnt;
            if (cnt == CNT_REPEAT)
                expected_kmers = {expected_kmers, win_code};
        end
    endtask

    task automatic add_word(input logic kind, input logic [7:0] ch);
        t_word w;
        w.kind = kind;
        w.nuc  = ch;
        pending_words = {pending_words, w};
        if (kind == KIND_START)
            n_starts++;
    endtask

    // pick a letter: upper case ACGT, or any case when mixed is set
    function automatic logic [7:0] pick_letter(input bit mixed);
        logic [7:0] ch;
        case ($urandom_range(0, 3))
            0:       ch = CH_A;
            1:       ch = CH_C;
            2:       ch = CH_G;
            default: ch = CH_T;
        endcase
        if (mixed && $urandom_range(0, 1) == 1)
            ch = ch | 8'h20;
        return ch;
    endfunction

    // directed words: short sequence, all-T and all-zero windows, odd bytes
    task automatic build_directed();
        add_word(KIND_BASE, CH_A);
        add_word(KIND_BASE, CH_C);
        add_word(KIND_BASE, CH_G);
        add_word(KIND_BASE, CH_T);
        add_word(KIND_START, CH_T);
        repeat (WINDOW_LEN + 1) add_word(KIND_BASE, CH_T);
        add_word(KIND_START, 8'h00);
        add_word(KIND_BASE, 8'h61);
        add_word(KIND_BASE, 8'hFF);
        add_word(KIND_BASE, 8'h00);
        add_word(KIND_BASE, 8'h74);
        add_word(KIND_BASE, 8'h80);
        repeat (WINDOW_LEN - 4) add_word(KIND_BASE, CH_A);
    endtask

    // random sequences: mostly periodic motifs that repeat k-mers, some noise
    task automatic build_random();
        int         stop_at;
        int         flavor;
        int         seq_len;
        int         period;
        logic [7:0] motif[8];
        logic [7:0] ch;
        stop_at = pending_words.size() + RANDOM_WORDS;
        while (pending_words.size() < stop_at && n_starts < MAX_STARTS) begin
            add_word(KIND_START, 8'($urandom_range(0, 255)));
            flavor  = $urandom_range(0, 9);
            seq_len = (flavor == 9) ? $urandom_range(1, WINDOW_LEN - 1) : $urandom_range(8, 40);
            period  = $urandom_range(1, 8);
            for (int j = 0; j < period; j++)
                motif[j] = pick_letter(1'b0);
            for (int j = 0; j < seq_len; j++) begin
                if (flavor <= 5)
                    ch = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                      : motif[j % period];
                else if (flavor <= 7)
                    ch = 8'($urandom_range(0, 255));
                else
                    ch = pick_letter(1'b1);
                add_word(KIND_BASE, ch);
            end
        end
    endtask

    // sender: predict on acceptance, then offer the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_kmer(i_kind, i_nucleotide);
                n_accepted <= n_accepted + 1;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    next_word = pending_words.pop_front();
                    i_valid      <= 1'b1;
                    i_kind       <= next_word.kind;
                    i_nucleotide <= next_word.nuc;
                    if (pending_words.size() >= TAIL_WORDS && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 12);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: one long hold-off, then random stall bursts, none at the tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
            hold_done  <= 1'b1;
            i_stall    <= 1'b1;
            stall_left <= HOLD_CYCLES;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (pending_words.size() < TAIL_WORDS) begin
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 11);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor: compare each accepted k-mer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (expected_kmers.size() == 0) begin
                $display("%0t: unexpected k-mer, expected none, actual %05h",
                         $time, o_kmer_code);
                n_errors++;
            end else begin
                want_code = expected_kmers.pop_front();
                if (o_kmer_code !== want_code) begin
                    $display("%0t: k-mer mismatch, expected %05h, actual %05h",
                             $time, want_code, o_kmer_code);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // fill the stimulus, release reset, drain and report
    initial begin
        build_directed();
        build_random();
        total_words = pending_words.size();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (n_accepted < total_words)
            @(posedge i_clk);
        while (expected_kmers.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d words over %0d sequences, %0d repeated k-mers seen.",
                 total_words, n_starts, n_results);
        $display("Mismatches and unexpected k-mers: %0d", n_errors);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- repeated_kmer_detector_unit.f -----
+incdir+hdl
hdl/rkd_pkg.sv
hdl/rkd_counter.sv
hdl/repeated_kmer_detector_unit.sv
tb/sv/tb_top.sv
